[src/vmct_pkg.sv]
`timescale 1ns / 1ps
// vmct_pkg: shared codes and field widths for the value mode count tracker
// no dependencies

package vmct_pkg;

  // input field widths
  localparam int unsigned ValW = 8;
  localparam int unsigned ActW = 2;

  // output field widths
  localparam int unsigned AmtW = 12;

  // action codes
  localparam logic [ActW-1:0] ACT_LOAD   = 2'd0;
  localparam logic [ActW-1:0] ACT_COMMIT = 2'd1;
  localparam logic [ActW-1:0] ACT_TRIAL  = 2'd2;

  // result kind codes
  localparam logic KIND_ERROR = 1'b0;
  localparam logic KIND_DELTA = 1'b1;

endpackage

[src/value_mode_count_tracker.sv]
`timescale 1ns / 1ps
// value_mode_count_tracker: histogram of variable values with mode distance report
// depends on vmct_pkg and vmct_ram
//
// Keeps a committed histogram and a scratch histogram in two ram banks and runs
// every transaction through one sequencer with a single read-modify-write path and
// a single sweep counter. For each accepted input transaction in_ready_o stays low
// until its work is done: a load marked first starts with a clearing sweep, a trial
// marked first with a copy sweep of the committed bank into scratch, and a load or
// trial marked last ends with a peak scan over all bins and a result step. After
// reset the block runs a clearing pass over the committed bank with in_ready_o low.
// Results sit in an output register, so the next input transaction is taken while
// a result waits; a later result waits in turn until that register frees up.

module value_mode_count_tracker
  import vmct_pkg::*;
#(
  parameter int unsigned NUM_VALUES = 256,
  parameter int unsigned MAX_VARS   = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input channel
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [ActW-1:0]        action_i,
  input  logic                   first_i,
  input  logic                   last_i,
  input  logic [ValW-1:0]        old_value_i,
  input  logic [ValW-1:0]        dest_value_i,
  // output channel
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   kind_o,
  output logic signed [AmtW-1:0] amount_o
);

  // bin index width and count width
  localparam int unsigned AW = $clog2(NUM_VALUES);
  localparam int unsigned CW = $clog2(MAX_VARS + 1);

  localparam logic [AW:0]   NumCnt  = (AW+1)'(NUM_VALUES);
  localparam logic [AW:0]   LastCnt = (AW+1)'(NUM_VALUES - 1);
  localparam logic [CW-1:0] MaxCnt  = CW'(MAX_VARS);

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLEAR  = 4'd1;
  localparam logic [3:0] S_COPY   = 4'd2;
  localparam logic [3:0] S_RD_OLD = 4'd3;
  localparam logic [3:0] S_WR_OLD = 4'd4;
  localparam logic [3:0] S_RD_NEW = 4'd5;
  localparam logic [3:0] S_WR_NEW = 4'd6;
  localparam logic [3:0] S_SCAN   = 4'd7;
  localparam logic [3:0] S_EMIT   = 4'd8;

  logic [3:0]            state_q, state_d;
  logic [AW:0]           cnt_q, cnt_d;
  logic                  init_q, init_d;
  logic [ActW-1:0]       act_q, act_d;
  logic                  last_q, last_d;
  logic [ValW-1:0]       old_q, old_d;
  logic [ValW-1:0]       new_q, new_d;
  logic [CW-1:0]         total_q, total_d;
  logic [CW-1:0]         peak_b_q, peak_b_d;
  logic [CW-1:0]         peak_s_q, peak_s_d;
  logic                  out_valid_q, out_valid_d;
  logic                  kind_q, kind_d;
  logic signed [AmtW-1:0] amount_q, amount_d;

  // ram ports
  logic          bin_we, scr_we;
  logic [AW-1:0] waddr, raddr;
  logic [CW-1:0] wdata;
  logic [CW-1:0] bin_rdata, scr_rdata, tgt_rdata;

  logic          in_acc;
  logic          old_ok, new_ok;
  logic          is_trial;
  logic [AW-1:0] cnt_idx, cnt_prev_idx;
  logic [AW:0]   cnt_prev;
  logic          sweep_rd;
  logic signed [CW:0] diff;

  vmct_ram #(
    .Depth(NUM_VALUES),
    .Width(CW)
  ) u_bin_ram (
    .clk_i  (clk_i),
    .we_i   (bin_we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(bin_rdata)
  );

  vmct_ram #(
    .Depth(NUM_VALUES),
    .Width(CW)
  ) u_scr_ram (
    .clk_i  (clk_i),
    .we_i   (scr_we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(scr_rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;

  // values beyond the histogram are ignored
  assign old_ok   = (32'(old_q) < NUM_VALUES);
  assign new_ok   = (32'(new_q) < NUM_VALUES);
  assign is_trial = (act_q == ACT_TRIAL);

  // trial moves work on the scratch bank, everything else on the committed one
  assign tgt_rdata = is_trial ? scr_rdata : bin_rdata;

  // in read sweeps the counter runs one past the last bin so the registered read drains
  assign cnt_idx      = cnt_q[AW-1:0];
  assign cnt_prev     = cnt_q - (AW+1)'(1);
  assign cnt_prev_idx = cnt_prev[AW-1:0];
  assign sweep_rd     = (cnt_q < NumCnt);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    init_d      = init_q;
    act_d       = act_q;
    last_d      = last_q;
    old_d       = old_q;
    new_d       = new_q;
    total_d     = total_q;
    peak_b_d    = peak_b_q;
    peak_s_d    = peak_s_q;
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    amount_d    = amount_q;

    bin_we = 1'b0;
    scr_we = 1'b0;
    waddr  = cnt_idx;
    wdata  = '0;
    raddr  = '0;
    diff   = '0;

    // output register drains independently of the sequencer
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          act_d  = action_i;
          last_d = last_i;
          old_d  = old_value_i;
          new_d  = dest_value_i;
          cnt_d  = '0;
          case (action_i)
            ACT_LOAD: begin
              if (first_i) begin
                total_d = '0;
                state_d = S_CLEAR;
              end else begin
                state_d = S_RD_NEW;
              end
            end
            ACT_COMMIT: begin
              state_d = S_RD_OLD;
            end
            ACT_TRIAL: begin
              state_d = first_i ? S_COPY : S_RD_OLD;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      // zero every committed bin, one per cycle
      S_CLEAR: begin
        bin_we = 1'b1;
        waddr  = cnt_idx;
        wdata  = '0;
        if (cnt_q == LastCnt) begin
          cnt_d = '0;
          if (init_q) begin
            init_d  = 1'b0;
            state_d = S_IDLE;
          end else begin
            state_d = S_RD_NEW;
          end
        end else begin
          cnt_d = cnt_q + (AW+1)'(1);
        end
      end

      // read committed bin i, write it to scratch in the following cycle
      S_COPY: begin
        raddr = sweep_rd ? cnt_idx : '0;
        if (cnt_q != '0) begin
          scr_we = 1'b1;
          waddr  = cnt_prev_idx;
          wdata  = bin_rdata;
        end
        if (cnt_q == NumCnt) begin
          cnt_d   = '0;
          state_d = S_RD_OLD;
        end else begin
          cnt_d = cnt_q + (AW+1)'(1);
        end
      end

      S_RD_OLD: begin
        raddr   = AW'(old_q);
        state_d = old_ok ? S_WR_OLD : S_RD_NEW;
      end

      // decrement, saturating at zero
      S_WR_OLD: begin
        waddr = AW'(old_q);
        wdata = tgt_rdata - CW'(1);
        if (tgt_rdata != '0) begin
          bin_we = ~is_trial;
          scr_we = is_trial;
        end
        state_d = S_RD_NEW;
      end

      S_RD_NEW: begin
        raddr = AW'(new_q);
        if (new_ok) begin
          if ((act_q == ACT_LOAD) && (total_q < MaxCnt)) begin
            total_d = total_q + CW'(1);
          end
          state_d = S_WR_NEW;
        end else if (last_q && (act_q != ACT_COMMIT)) begin
          cnt_d    = '0;
          peak_b_d = '0;
          peak_s_d = '0;
          state_d  = S_SCAN;
        end else begin
          state_d = S_IDLE;
        end
      end

      // increment, saturating at the variable count
      S_WR_NEW: begin
        waddr = AW'(new_q);
        wdata = tgt_rdata + CW'(1);
        if (tgt_rdata < MaxCnt) begin
          bin_we = ~is_trial;
          scr_we = is_trial;
        end
        if (last_q && (act_q != ACT_COMMIT)) begin
          cnt_d    = '0;
          peak_b_d = '0;
          peak_s_d = '0;
          state_d  = S_SCAN;
        end else begin
          state_d = S_IDLE;
        end
      end

      // running maximum over both banks, read data arrives in the cycle after its address
      S_SCAN: begin
        raddr = sweep_rd ? cnt_idx : '0;
        if (cnt_q != '0) begin
          if (bin_rdata > peak_b_q) begin
            peak_b_d = bin_rdata;
          end
          if (scr_rdata > peak_s_q) begin
            peak_s_d = scr_rdata;
          end
        end
        if (cnt_q == NumCnt) begin
          cnt_d   = '0;
          state_d = S_EMIT;
        end else begin
          cnt_d = cnt_q + (AW+1)'(1);
        end
      end

      // hand the result over once the output register is free
      S_EMIT: begin
        if (is_trial) begin
          diff = $signed({1'b0, peak_b_q}) - $signed({1'b0, peak_s_q});
        end else begin
          diff = $signed({1'b0, total_q}) - $signed({1'b0, peak_b_q});
        end
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          kind_d      = is_trial ? KIND_DELTA : KIND_ERROR;
          amount_d    = AmtW'(diff);
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      init_q      <= 1'b1;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      init_q      <= init_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  // transaction payload and scan results
  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    last_q   <= last_d;
    old_q    <= old_d;
    new_q    <= new_d;
    peak_b_q <= peak_b_d;
    peak_s_q <= peak_s_d;
    kind_q   <= kind_d;
    amount_q <= amount_d;
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign amount_o    = amount_q;

  // a scan only ever runs for a load or trial marked last
  a_scan_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (last_q && ((act_q == ACT_LOAD) || (act_q == ACT_TRIAL))))
    else $error("peak scan started by a transaction that emits no result");

  // sweeps never run past the drain step
  a_sweep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SCAN) || (state_q == S_COPY) || (state_q == S_CLEAR)) |->
    (cnt_q <= NumCnt))
    else $error("sweep counter out of range");

  // a fresh result only comes out of the emit step
  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == S_EMIT))
    else $error("result presented outside the emit step");

  // an unused action code returns straight to idle
  a_unused_act: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (action_i != ACT_LOAD) && (action_i != ACT_COMMIT) &&
     (action_i != ACT_TRIAL)) |=> (state_q == S_IDLE))
    else $error("unused action code started work");

endmodule

[src/vmct_ram.sv]
`timescale 1ns / 1ps
// vmct_ram: simple dual port ram, one write and one registered read per cycle
// no dependencies

module vmct_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 11
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// tb: self-checking testbench for value_mode_count_tracker
// depends on vmct_pkg and the value_mode_count_tracker rtl, nothing else

module tb;
  import vmct_pkg::*;

  localparam int unsigned NumValues = 256;
  localparam int unsigned MaxVars   = 1024;

  // action 3 has no meaning, the block must drop it silently
  localparam logic [ActW-1:0] ACT_UNUSED = 2'd3;

  // number of random load/commit/trial transactions after the directed part
  localparam int unsigned RandomItems = 450;
  // loads that push one bin and the total past saturation
  localparam int unsigned SatLoads = 1040;

  // budget per transaction covers the worst one, a trial first and last, plus the
  // longest source gap and the longest sink stall; about 1600 transactions in
  // all, then three times over, plus the clearing pass after reset
  localparam int unsigned CycleLimit = 3 * 1600 * 640 + NumValues + 1000;
  // settle time after the last expected result (longest single transaction)
  localparam int unsigned DrainCycles = 600;

  typedef struct packed {
    logic [ActW-1:0] action;
    logic            first;
    logic            last;
    logic [ValW-1:0] old_value;
    logic [ValW-1:0] dest_value;
  } tracker_txn_t;

  typedef struct packed {
    logic                   kind;
    logic signed [AmtW-1:0] amount;
  } tracker_result_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic [ActW-1:0]        action_i;
  logic                   first_i;
  logic                   last_i;
  logic [ValW-1:0]        old_value_i;
  logic [ValW-1:0]        dest_value_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic                   kind_o;
  logic signed [AmtW-1:0] amount_o;

  value_mode_count_tracker #(
    .NUM_VALUES(NumValues),
    .MAX_VARS  (MaxVars)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .first_i     (first_i),
    .last_i      (last_i),
    .old_value_i (old_value_i),
    .dest_value_i(dest_value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .amount_o    (amount_o)
  );

  // ---------------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // shadow histogram: bank 0 is the committed store, bank 1 the scratch copy
  // ---------------------------------------------------------------------------
  logic [10:0] hist [2][NumValues];
  logic [10:0] load_total;

  tracker_txn_t    pending_q [$];          // transactions not yet driven
  tracker_result_t expected_results_q [$]; // results still owed by the block

  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  int unsigned work_items  = 0;

  // generator side: scratch must be seeded by a trial marked first before
  // any trial may lean on it
  bit scratch_loaded = 1'b0;

  // counts saturate at zero on the way down and at MaxVars on the way up
  function automatic void bump_bin(input int bank, input logic [ValW-1:0] v, input bit up);
    if (up) begin
      if (hist[bank][v] < MaxVars) hist[bank][v] = hist[bank][v] + 11'd1;
    end else begin
      if (hist[bank][v] > 0) hist[bank][v] = hist[bank][v] - 11'd1;
    end
  endfunction

  function automatic int peak_of_bank(input int bank);
    int best;
    best = 0;
    for (int i = 0; i < NumValues; i++)
      if (int'(hist[bank][i]) > best) best = int'(hist[bank][i]);
    return best;
  endfunction

  // advance the shadow state by one accepted transaction and queue what it owes
  task automatic track_transaction(input tracker_txn_t t);
    tracker_result_t res;
    case (t.action)
      ACT_LOAD: begin
        if (t.first) begin
          for (int i = 0; i < NumValues; i++) hist[0][i] = '0;
          load_total = '0;
        end
        bump_bin(0, t.dest_value, 1'b1);
        if (load_total < MaxVars) load_total = load_total + 11'd1;
        if (t.last) begin
          res.kind   = KIND_ERROR;
          res.amount = AmtW'(int'(load_total) - peak_of_bank(0));
          expected_results_q.push_back(res);
        end
      end
      ACT_COMMIT: begin
        // last has no effect on a commit
        bump_bin(0, t.old_value, 1'b0);
        bump_bin(0, t.dest_value, 1'b1);
      end
      ACT_TRIAL: begin
        if (t.first)
          for (int i = 0; i < NumValues; i++) hist[1][i] = hist[0][i];
        bump_bin(1, t.old_value, 1'b0);
        bump_bin(1, t.dest_value, 1'b1);
        if (t.last) begin
          res.kind   = KIND_DELTA;
          res.amount = AmtW'(peak_of_bank(0) - peak_of_bank(1));
          expected_results_q.push_back(res);
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_result(input logic kind, input logic signed [AmtW-1:0] amount);
    tracker_result_t exp_res;
    if (expected_results_q.size() == 0) begin
      $display("%0t: result with nothing pending: kind %0d amount %0d", $time, kind, amount);
      mismatches++;
    end else begin
      exp_res = expected_results_q.pop_front();
      if (kind !== exp_res.kind) begin
        $display("%0t: kind expected %0d actual %0d", $time, exp_res.kind, kind);
        mismatches++;
      end
      if (amount !== exp_res.amount) begin
        $display("%0t: amount expected %0d actual %0d", $time, exp_res.amount, amount);
        mismatches++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------
  task automatic add_item(input logic [ActW-1:0] action, input logic first, input logic last,
                          input logic [ValW-1:0] old_value, input logic [ValW-1:0] dest_value);
    tracker_txn_t t;
    t.action     = action;
    t.first      = first;
    t.last       = last;
    t.old_value  = old_value;
    t.dest_value = dest_value;
    pending_q.push_back(t);
    if (action != ACT_UNUSED) work_items++;
  endtask

  // mostly a small cluster around base so bins pile up, sometimes anything
  function automatic logic [ValW-1:0] pick_value(input int unsigned base);
    if ($urandom_range(0, 9) < 7) return ValW'(base + $urandom_range(0, 3));
    return ValW'($urandom_range(0, 255));
  endfunction

  task automatic build_directed();
    // single load on a cleared store: error 0
    add_item(ACT_LOAD, 1'b1, 1'b1, 8'h00, 8'h00);
    // extremes of the value range, error 1
    add_item(ACT_LOAD, 1'b1, 1'b0, 8'hff, 8'hff);
    add_item(ACT_LOAD, 1'b0, 1'b0, 8'h00, 8'hff);
    add_item(ACT_LOAD, 1'b0, 1'b1, 8'hff, 8'h00);
    // commit out of an empty bin clamps at zero
    add_item(ACT_COMMIT, 1'b0, 1'b0, 8'h07, 8'hff);
    // commit marked last and first must not answer
    add_item(ACT_COMMIT, 1'b1, 1'b1, 8'hff, 8'h00);
    // unused action with every flag set is dropped
    add_item(ACT_UNUSED, 1'b1, 1'b1, 8'hff, 8'hff);
    add_item(ACT_UNUSED, 1'b0, 1'b0, 8'h00, 8'h00);
    // two-step trial run
    add_item(ACT_TRIAL, 1'b1, 1'b0, 8'hff, 8'h80);
    add_item(ACT_TRIAL, 1'b0, 1'b1, 8'h00, 8'hff);
    // one-step trial, move onto itself
    add_item(ACT_TRIAL, 1'b1, 1'b1, 8'h01, 8'h01);
    // trial that leaves an empty bin: scratch clamps at zero
    add_item(ACT_TRIAL, 1'b1, 1'b1, 8'h42, 8'h00);
    // trial continuing an older scratch without first
    add_item(ACT_TRIAL, 1'b0, 1'b1, 8'h80, 8'h80);
    // load appended without first
    add_item(ACT_LOAD, 1'b0, 1'b1, 8'h55, 8'h80);
    // load with first and last on a non-empty store
    add_item(ACT_LOAD, 1'b1, 1'b1, 8'haa, 8'h7f);
    scratch_loaded = 1'b1;
  endtask

  // drive one bin and the total into saturation, then poke around the ceiling
  task automatic build_saturation();
    logic [ValW-1:0] hot;
    logic [ValW-1:0] cold;
    hot  = ValW'($urandom_range(0, 255));
    cold = hot ^ 8'h80;
    add_item(ACT_LOAD, 1'b1, 1'b0, 8'h00, hot);
    for (int i = 0; i < SatLoads; i++)
      add_item(ACT_LOAD, 1'b0, 1'b0, ValW'($urandom),
               ($urandom_range(0, 49) == 0) ? ValW'($urandom_range(0, 255)) : hot);
    add_item(ACT_LOAD, 1'b0, 1'b1, 8'h00, cold);
    // commits into a full bin stay clamped at the ceiling
    for (int i = 0; i < 4; i++)
      add_item(ACT_COMMIT, 1'b0, 1'b0, cold, hot);
    add_item(ACT_TRIAL, 1'b1, 1'b1, cold, hot);
    add_item(ACT_TRIAL, 1'b1, 1'b1, hot, cold);
    add_item(ACT_LOAD, 1'b0, 1'b1, 8'hff, cold);
  endtask

  task automatic build_random();
    int unsigned stop_at;
    int unsigned pick;
    int unsigned base;
    int unsigned len;
    bit          opens;
    bit          closes;
    logic [ActW-1:0] act;
    stop_at = work_items + RandomItems;
    while (work_items < stop_at) begin
      pick = $urandom_range(0, 99);
      base = $urandom_range(0, 252);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
      if (pick < 40) begin
        // load run, usually opened by a first
        opens = ($urandom_range(0, 9) != 0);
        for (int i = 0; i < len; i++)
          add_item(ACT_LOAD, opens && i == 0, i == len - 1, ValW'($urandom), pick_value(base));
      end else if (pick < 62) begin
        // commit burst with random flags, which the block ignores
        for (int i = 0; i < len && i < 6; i++)
          add_item(ACT_COMMIT, 1'($urandom), 1'($urandom), pick_value(base), pick_value(base));
      end else if (pick < 92) begin
        // trial run; occasionally left open or reusing the last scratch
        opens  = !scratch_loaded || ($urandom_range(0, 6) != 0);
        closes = ($urandom_range(0, 9) != 0);
        if (len > 5 && $urandom_range(0, 3) != 0) len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++)
          add_item(ACT_TRIAL, opens && i == 0, closes && i == len - 1,
                   pick_value(base), pick_value(base));
        if (opens) scratch_loaded = 1'b1;
      end else begin
        // noise: unused actions and stray transactions with random flags
        act = ActW'($urandom_range(0, 3));
        opens = 1'($urandom);
        if (act == ACT_TRIAL && !scratch_loaded) opens = 1'b1;
        if (act == ACT_TRIAL && opens) scratch_loaded = 1'b1;
        add_item(act, opens, 1'($urandom), ValW'($urandom), ValW'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // idle pattern: calm stretches with no gaps alternate with noisy ones
  // ---------------------------------------------------------------------------
  bit          calm      = 1'b0;
  int unsigned mode_left = 0;

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // source driver: falling edge, holds payload until the transaction is taken
  // ---------------------------------------------------------------------------
  bit           in_taken = 1'b0; // set by the monitor at the rising edge
  int unsigned  in_gap   = 0;
  tracker_txn_t next_txn;

  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_q.size() > 0) begin
        next_txn      = pending_q.pop_front();
        action_i     <= next_txn.action;
        first_i      <= next_txn.first;
        last_i       <= next_txn.last;
        old_value_i  <= next_txn.old_value;
        dest_value_i <= next_txn.dest_value;
        in_valid_i   <= 1'b1;
        in_gap        = pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sink driver: random back-pressure on the result channel
  // ---------------------------------------------------------------------------
  int unsigned sink_stall = 0;

  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      mode_left = $urandom_range(100, 400);
      calm      = ($urandom_range(0, 3) == 0);
    end else begin
      mode_left--;
    end
    if (rst_ni) begin
      if (sink_stall > 0) begin
        sink_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        sink_stall   = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: samples both channels at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cycle_count++;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) check_result(kind_o, amount_o);
      in_taken = in_valid_i && in_ready_o;
      if (in_taken)
        track_transaction({action_i, first_i, last_i, old_value_i, dest_value_i});
    end
  end

  // ---------------------------------------------------------------------------
  // timeout
  // ---------------------------------------------------------------------------
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    action_i     = ACT_LOAD;
    first_i      = 1'b0;
    last_i       = 1'b0;
    old_value_i  = '0;
    dest_value_i = '0;
    out_ready_i  = 1'b0;
    for (int i = 0; i < NumValues; i++) hist[0][i] = '0;
    load_total = '0;

    build_directed();
    build_saturation();
    build_random();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // every transaction handed over, then every result collected
    wait (pending_q.size() == 0 && !in_valid_i);
    wait (expected_results_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[value_mode_count_tracker.f]
src/vmct_pkg.sv
src/vmct_ram.sv
src/value_mode_count_tracker.sv
test/tb.sv
